FILE: hw/rtl/pwsm_pkg.sv
// ----------------------------------------------------------------------------
// pwsm_pkg
// Shared types and constants of the pulse width speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwsm_pkg;

  localparam int SampleW    = 12;
  localparam int TimestampW = 32;
  localparam int SpeedW     = 28;
  localparam int LastWidthW = 32;

  localparam int ThresholdW  = 12;
  localparam int HysteresisW = 11;
  localparam int LineWidthW  = 16;

  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam int DefHistoryDepth = 3;
  localparam int DefTimeWidth    = 32;

  localparam longint LineWidthMax = 65535;
  localparam longint UmPerMm      = 1000;

  localparam logic [ThresholdW-1:0]  ThresholdRst  = 12'd4000;
  localparam logic [HysteresisW-1:0] HysteresisRst = 11'd0;
  localparam logic [LineWidthW-1:0]  LineWidthRst  = 16'd873;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_HYSTERESIS = 2'd1,
    REG_LINE_WIDTH = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0]    sample;
    logic [TimestampW-1:0] timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic [SpeedW-1:0]     speed_mm_s;
    logic                  speed_valid;
    logic                  pulse_done;
    logic [LastWidthW-1:0] last_width_us;
  } out_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pwsm_if.sv
// ----------------------------------------------------------------------------
// pwsm_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwsm_in_if;
  logic               valid;
  logic               ready;
  pwsm_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pwsm_out_if;
  logic                valid;
  logic                ready;
  pwsm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pwsm_div.sv
// ----------------------------------------------------------------------------
// pwsm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsm_div #(
  parameter int NumW = 28,
  parameter int DenW = 34
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            bit_d;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign bit_d = ~diff[DenW];
  assign rem_d = bit_d ? diff[DenW-1:0] : trial[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NumW-2:0], bit_d};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pulse_width_speed_meter.sv
// ----------------------------------------------------------------------------
// pulse_width_speed_meter
// Optical tachometer channel: pulse width history and averaged line speed.
// ----------------------------------------------------------------------------
// Each sample word yields one result word. A sample below threshold minus
// hysteresis arms the channel and latches its timestamp; a sample above
// threshold plus hysteresis while armed closes the pulse and shifts its width
// into a HISTORY_DEPTH entry history. The speed is line_width_um * 1000 *
// HISTORY_DEPTH / sum(history), truncated, 0 with speed_valid low while the
// sum is zero. One item at a time: each word passes through the serial history
// sum (one entry per cycle) and the restoring divider (one quotient bit per
// cycle, NumW = 28); with a zero history sum the divider is skipped.
// The result register lets the next sample in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_speed_meter #(
  parameter int HISTORY_DEPTH = pwsm_pkg::DefHistoryDepth,
  parameter int TIME_WIDTH    = pwsm_pkg::DefTimeWidth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  pwsm_in_if.sink                          in_i,
  pwsm_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pwsm_pkg::PaddrW-1:0] paddr,
  input  wire logic [pwsm_pkg::PdataW-1:0] pwdata,
  output logic      [pwsm_pkg::PdataW-1:0] prdata,
  output logic                             pready
);

  localparam int     IdxW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int     SumW     = TIME_WIDTH + $clog2(HISTORY_DEPTH);
  localparam longint NumScale = pwsm_pkg::UmPerMm * HISTORY_DEPTH;
  localparam longint NumMax   = pwsm_pkg::LineWidthMax * NumScale;
  localparam int     NumW     = $clog2(NumMax + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_e;

  // configuration
  logic [pwsm_pkg::ThresholdW-1:0]  thr_q;
  logic [pwsm_pkg::HysteresisW-1:0] hys_q;
  logic [pwsm_pkg::LineWidthW-1:0]  lw_q;
  pwsm_pkg::reg_idx_e               reg_idx;
  logic                             cfg_wr;

  assign reg_idx = pwsm_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= pwsm_pkg::ThresholdRst;
      hys_q <= pwsm_pkg::HysteresisRst;
      lw_q  <= pwsm_pkg::LineWidthRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        pwsm_pkg::REG_THRESHOLD:  thr_q <= pwdata[pwsm_pkg::ThresholdW-1:0];
        pwsm_pkg::REG_HYSTERESIS: hys_q <= pwdata[pwsm_pkg::HysteresisW-1:0];
        pwsm_pkg::REG_LINE_WIDTH: lw_q  <= pwdata[pwsm_pkg::LineWidthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pwsm_pkg::REG_THRESHOLD:  prdata = pwsm_pkg::PdataW'(thr_q);
      pwsm_pkg::REG_HYSTERESIS: prdata = pwsm_pkg::PdataW'(hys_q);
      pwsm_pkg::REG_LINE_WIDTH: prdata = pwsm_pkg::PdataW'(lw_q);
      default:                  prdata = '0;
    endcase
  end

  // pulse detection
  state_e                  state_q;
  logic                    armed_q;
  logic [TIME_WIDTH-1:0]   start_q;
  logic [TIME_WIDTH-1:0]   hist_q [HISTORY_DEPTH];
  logic [SumW-1:0]         sum_q;
  logic [IdxW-1:0]         idx_q;
  logic                    done_q;
  logic                    valid_q;
  logic [NumW-1:0]         num_q;
  logic                    out_valid_q;
  pwsm_pkg::out_word_t     out_q;

  logic                    in_acc;
  logic signed [12:0]      low_edge;
  logic        [12:0]      high_edge;
  logic                    arm;
  logic                    fin;
  logic [TIME_WIDTH-1:0]   now;
  logic                    div_start;
  logic                    div_busy;
  logic [NumW-1:0]         quot;
  logic                    out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign now        = TIME_WIDTH'(in_i.data.timestamp_us);
  assign low_edge   = $signed({1'b0, thr_q}) - $signed({2'b00, hys_q});
  assign high_edge  = {1'b0, thr_q} + {2'b00, hys_q};
  assign arm        = ($signed({1'b0, in_i.data.sample}) < low_edge) & ~armed_q;
  assign fin        = ({1'b0, in_i.data.sample} > high_edge) & armed_q;
  assign div_start  = (state_q == ST_START) & (sum_q != '0);
  assign out_free   = ~out_valid_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b0;
      start_q     <= '0;
      hist_q      <= '{default: '0};
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (arm) begin
              armed_q <= 1'b1;
              start_q <= now;
            end
            if (fin) begin
              armed_q <= 1'b0;
              for (int i = 0; i + 1 < HISTORY_DEPTH; i++) begin
                hist_q[i] <= hist_q[i+1];
              end
              hist_q[HISTORY_DEPTH-1] <= now - start_q;
            end
            idx_q   <= '0;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == IdxW'(HISTORY_DEPTH - 1)) begin
            state_q <= ST_START;
          end
        end
        ST_START: begin
          state_q <= (sum_q != '0) ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (!div_busy) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          done_q <= fin;
          sum_q  <= '0;
          num_q  <= NumW'({{(NumW - pwsm_pkg::LineWidthW){1'b0}}, lw_q}
                          * NumW'(NumScale));
        end
      end
      ST_SUM: begin
        sum_q <= sum_q + SumW'(hist_q[idx_q]);
      end
      ST_START: begin
        valid_q <= (sum_q != '0);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_q.speed_mm_s    <= valid_q ? pwsm_pkg::SpeedW'(quot) : '0;
          out_q.speed_valid   <= valid_q;
          out_q.pulse_done    <= done_q;
          out_q.last_width_us <= pwsm_pkg::LastWidthW'(hist_q[HISTORY_DEPTH-1]);
        end
      end
      default: ;
    endcase
  end

  pwsm_div #(
    .NumW (NumW),
    .DenW (SumW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (sum_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire
